[hw/rtl/ipst_pkg.sv]
// ----------------------------------------------------------------------------
// ipst_pkg
// Shared sizes, codes and structs of the incremental prime sieve table.
// ----------------------------------------------------------------------------
`default_nettype none

package ipst_pkg;

   localparam int VALUE_BITS    = 32;
   localparam int TABLE_DEPTH   = 8192;
   localparam int SEGMENT_SIZE  = 4096;

   localparam int TABLE_ADDR_BITS = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS      = $clog2(TABLE_DEPTH + 1);
   localparam int SEG_ADDR_BITS   = $clog2(SEGMENT_SIZE);
   localparam int SEG_LEN_BITS    = $clog2(SEGMENT_SIZE + 1);
   localparam int DIV_STEP_BITS   = $clog2(VALUE_BITS + 1);

   localparam int CMD_BITS    = 2;
   localparam int INDEX_BITS  = 14;
   localparam int STATUS_BITS = 2;
   localparam int ANSWER_BITS = 32;
   localparam int SCOUNT_BITS = 14;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_EXTEND       = 2'd0,
      CMD_EXTEND_COUNT = 2'd1,
      CMD_READ         = 2'd2,
      CMD_CLEAR        = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK    = 2'd0,
      STAT_INDEX = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                  start;
      logic [VALUE_BITS-1:0] dividend;
      logic [VALUE_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

[hw/rtl/ipst_if.sv]
// ----------------------------------------------------------------------------
// ipst_req_if / ipst_rsp_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] limit_value;
   logic [13:0] prime_index;

   modport source (output valid, output command, output limit_value, output prime_index,
                   input ready);
   modport sink   (input valid, input command, input limit_value, input prime_index,
                   output ready);
endinterface

interface ipst_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] answer;
   logic [1:0]  status;
   logic [13:0] stored_count;
   logic [31:0] largest_sieved;

   modport source (output valid, output answer, output status, output stored_count,
                   output largest_sieved, input ready);
   modport sink   (input valid, input answer, input status, input stored_count,
                   input largest_sieved, output ready);
endinterface

`default_nettype wire

[hw/rtl/ipst_ram.sv]
// ----------------------------------------------------------------------------
// ipst_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ipst_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

[hw/rtl/ipst_rem.sv]
// ----------------------------------------------------------------------------
// ipst_rem
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipst_rem (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ipst_pkg::div_req_type div_req,
   output ipst_pkg::div_rsp_type      div_rsp
);
   import ipst_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [VALUE_BITS-1:0]    shift_ff, shift_in;
   logic [VALUE_BITS-1:0]    dsr_ff, dsr_in;
   logic [VALUE_BITS:0]      rem_ff, rem_in;
   logic [VALUE_BITS:0]      trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      dsr_in   = dsr_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff[VALUE_BITS-1:0], shift_ff[VALUE_BITS-1]};
      if (div_req.start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = div_req.dividend;
         dsr_in   = div_req.divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
         end else begin
            rem_in = trial;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_BITS'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      shift_ff <= shift_in;
      dsr_ff   <= dsr_in;
      rem_ff   <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff[VALUE_BITS-1:0];

endmodule

`default_nettype wire

[hw/rtl/incremental_prime_sieve_table_unit.sv]
// ----------------------------------------------------------------------------
// incremental_prime_sieve_table_unit
// Prime table grown by a segmented sieve; extend, count, read and clear.
// ----------------------------------------------------------------------------
//   channel   | dir | handshake   | payload
//   req_chan  | in  | valid/ready | command, limit_value, prime_index
//   rsp_chan  | out | valid/ready | answer, status, stored_count, largest_sieved
//
// One command at a time. An extend fills the flags of each segment, strikes the
// multiples of each striking prime after a remainder step, and scans every number,
// all bound by the single flag RAM port. A count reads the stored primes in turn.
// Reset clears the state, the counters and the output valid flag, not the RAMs.
// A finished result waits in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_prime_sieve_table_unit (
   input wire logic clock,
   input wire logic reset,
   ipst_req_if.sink   req_chan,
   ipst_rsp_if.source rsp_chan
);
   import ipst_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_SEED, S_SEG_SETUP, S_FILL, S_PRIME_RD, S_PRIME_WAIT, S_PRIME_SQ,
      S_DIV_WAIT, S_MARK, S_SCAN_RD, S_SCAN_CHK, S_SMARK, S_SEG_END, S_CNT_RD,
      S_CNT_CHK, S_READ_WAIT, S_FIN
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [VALUE_BITS-1:0]   limit_ff, limit_in;
   logic [COUNT_BITS-1:0]   total_ff, total_in;
   logic [VALUE_BITS-1:0]   largest_ff, largest_in;
   logic [VALUE_BITS-1:0]   lo_ff, lo_in;
   logic [VALUE_BITS-1:0]   hi_ff, hi_in;
   logic [SEG_LEN_BITS-1:0] len_ff, len_in;
   logic [SEG_LEN_BITS-1:0] i_ff, i_in;
   logic [COUNT_BITS-1:0]   k_ff, k_in;
   logic [VALUE_BITS-1:0]   p_ff, p_in;
   logic [2*VALUE_BITS-1:0] sq_ff, sq_in;
   logic [VALUE_BITS:0]     j_ff, j_in;
   logic [ANSWER_BITS-1:0]  answer_ff, answer_in;
   status_type              status_ff, status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ANSWER_BITS-1:0]  rsp_answer_ff, rsp_answer_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [SCOUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic [VALUE_BITS-1:0]   rsp_largest_ff, rsp_largest_in;

   logic                       st_we;
   logic [TABLE_ADDR_BITS-1:0] st_addr;
   logic [VALUE_BITS-1:0]      st_wdata, st_rdata;
   logic                       fl_we, fl_wdata, fl_rdata;
   logic [SEG_ADDR_BITS-1:0]   fl_addr;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [VALUE_BITS-1:0] diff;
   logic [VALUE_BITS-1:0] cand;
   logic                  accept;

   ipst_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(VALUE_BITS)) u_store (
      .clock(clock), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata)
   );

   ipst_ram #(.DEPTH(SEGMENT_SIZE), .WIDTH(1)) u_flags (
      .clock(clock), .we(fl_we), .addr(fl_addr), .wdata(fl_wdata), .rdata(fl_rdata)
   );

   ipst_rem u_rem (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign accept         = (state_ff == S_IDLE) && req_chan.valid;
   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      diff = limit_ff - lo_ff;
      cand = lo_ff + VALUE_BITS'(i_ff);
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      limit_in     = limit_ff;
      total_in     = total_ff;
      largest_in   = largest_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      p_in         = p_ff;
      sq_in        = sq_ff;
      j_in         = j_ff;
      answer_in    = answer_ff;
      status_in    = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_answer_in  = rsp_answer_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_largest_in = rsp_largest_ff;
      st_we    = 1'b0;
      st_addr  = k_ff[TABLE_ADDR_BITS-1:0];
      st_wdata = cand;
      fl_we    = 1'b0;
      fl_addr  = i_ff[SEG_ADDR_BITS-1:0];
      fl_wdata = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = lo_ff;
      div_req.divisor  = p_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = cmd_type'(req_chan.command);
               limit_in  = req_chan.limit_value;
               answer_in = '0;
               status_in = STAT_OK;
               case (cmd_type'(req_chan.command))
                  CMD_EXTEND, CMD_EXTEND_COUNT: begin
                     if (req_chan.limit_value <= largest_ff) begin
                        k_in     = '0;
                        state_in = (cmd_type'(req_chan.command) == CMD_EXTEND_COUNT) ?
                                   S_CNT_RD : S_FIN;
                     end else if (largest_ff == '0) begin
                        state_in = S_SEED;
                     end else begin
                        lo_in    = largest_ff + 1'b1;
                        state_in = S_SEG_SETUP;
                     end
                  end
                  CMD_READ: begin
                     if ({{(COUNT_BITS){1'b0}}, req_chan.prime_index} >=
                         {{(INDEX_BITS){1'b0}}, total_ff}) begin
                        status_in = STAT_INDEX;
                        state_in  = S_FIN;
                     end else begin
                        state_in  = S_READ_WAIT;
                     end
                  end
                  default: begin
                     total_in   = '0;
                     largest_in = '0;
                     state_in   = S_FIN;
                  end
               endcase
            end
            st_addr = req_chan.prime_index[TABLE_ADDR_BITS-1:0];
         end
         S_READ_WAIT: begin
            answer_in = st_rdata;
            state_in  = S_FIN;
         end
         S_SEED: begin
            st_we      = 1'b1;
            st_addr    = '0;
            st_wdata   = VALUE_BITS'(2);
            total_in   = COUNT_BITS'(1);
            largest_in = VALUE_BITS'(2);
            answer_in  = ANSWER_BITS'(1);
            if (limit_ff <= VALUE_BITS'(2)) begin
               k_in     = '0;
               state_in = (cmd_ff == CMD_EXTEND_COUNT) ? S_CNT_RD : S_FIN;
            end else begin
               lo_in    = VALUE_BITS'(3);
               state_in = S_SEG_SETUP;
            end
         end
         S_SEG_SETUP: begin
            if (diff < VALUE_BITS'(SEGMENT_SIZE - 1)) begin
               hi_in  = limit_ff;
               len_in = SEG_LEN_BITS'(diff) + 1'b1;
            end else begin
               hi_in  = lo_ff + VALUE_BITS'(SEGMENT_SIZE - 1);
               len_in = SEG_LEN_BITS'(SEGMENT_SIZE);
            end
            i_in     = '0;
            state_in = S_FILL;
         end
         S_FILL: begin
            fl_we    = 1'b1;
            fl_wdata = 1'b1;
            if (i_ff == len_ff - 1'b1) begin
               k_in     = '0;
               state_in = S_PRIME_RD;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_PRIME_RD: begin
            if (k_ff == total_ff) begin
               i_in     = '0;
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_PRIME_WAIT;
            end
         end
         S_PRIME_WAIT: begin
            p_in     = st_rdata;
            sq_in    = st_rdata * st_rdata;
            state_in = S_PRIME_SQ;
         end
         S_PRIME_SQ: begin
            if (p_ff < VALUE_BITS'(2) || sq_ff > {{(VALUE_BITS){1'b0}}, hi_ff}) begin
               i_in     = '0;
               state_in = S_SCAN_RD;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               j_in     = (div_rsp.remainder == '0) ? '0 :
                          {1'b0, p_ff - div_rsp.remainder};
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            fl_addr = j_ff[SEG_ADDR_BITS-1:0];
            if (j_ff < (VALUE_BITS+1)'(len_ff)) begin
               fl_we = 1'b1;
               j_in  = j_ff + {1'b0, p_ff};
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_PRIME_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = (i_ff == len_ff) ? S_SEG_END : S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (fl_rdata) begin
               if (total_ff == COUNT_BITS'(TABLE_DEPTH)) begin
                  status_in = STAT_FULL;
                  k_in      = '0;
                  state_in  = (cmd_ff == CMD_EXTEND_COUNT) ? S_CNT_RD : S_FIN;
               end else begin
                  st_we      = 1'b1;
                  st_addr    = total_ff[TABLE_ADDR_BITS-1:0];
                  total_in   = total_ff + 1'b1;
                  largest_in = cand;
                  answer_in  = answer_ff + 1'b1;
                  p_in       = cand;
                  if (cand < VALUE_BITS'(len_ff)) begin
                     j_in     = (VALUE_BITS+1)'(i_ff) + {1'b0, cand};
                     state_in = S_SMARK;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_SCAN_RD;
                  end
               end
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SMARK: begin
            fl_addr = j_ff[SEG_ADDR_BITS-1:0];
            if (j_ff < (VALUE_BITS+1)'(len_ff)) begin
               fl_we = 1'b1;
               j_in  = j_ff + {1'b0, p_ff};
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SEG_END: begin
            if (hi_ff == limit_ff) begin
               k_in     = '0;
               state_in = (cmd_ff == CMD_EXTEND_COUNT) ? S_CNT_RD : S_FIN;
            end else begin
               lo_in    = hi_ff + 1'b1;
               state_in = S_SEG_SETUP;
            end
         end
         S_CNT_RD: begin
            if (k_ff == total_ff) begin
               answer_in = ANSWER_BITS'(k_ff);
               state_in  = S_FIN;
            end else begin
               state_in  = S_CNT_CHK;
            end
         end
         S_CNT_CHK: begin
            if (st_rdata < limit_ff) begin
               k_in     = k_ff + 1'b1;
               state_in = S_CNT_RD;
            end else begin
               answer_in = ANSWER_BITS'(k_ff);
               state_in  = S_FIN;
            end
         end
         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_answer_in  = answer_ff;
               rsp_status_in  = status_ff;
               rsp_count_in   = SCOUNT_BITS'(total_ff);
               rsp_largest_in = largest_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         largest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         largest_ff   <= largest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      limit_ff       <= limit_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      len_ff         <= len_in;
      i_ff           <= i_in;
      k_ff           <= k_in;
      p_ff           <= p_in;
      sq_ff          <= sq_in;
      j_ff           <= j_in;
      answer_ff      <= answer_in;
      status_ff      <= status_in;
      rsp_answer_ff  <= rsp_answer_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_largest_ff <= rsp_largest_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.answer         = rsp_answer_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.stored_count   = rsp_count_ff;
   assign rsp_chan.largest_sieved = rsp_largest_ff;

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Regression for the incremental prime sieve table unit. A scoreboard class
// predicts every result from its own copy of the table. Directed commands hit
// the seeding, empty-range, table-full, index-range and clear cases. Random
// commands follow with small extend steps. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ipst_pkg::*;

   typedef struct {
      logic [31:0] answer;
      logic [1:0]  status;
      logic [13:0] stored_count;
      logic [31:0] largest_sieved;
   } sieve_result_type;

   class sieve_scoreboard;
      bit [31:0]        stored_primes[TABLE_DEPTH];
      longint unsigned  table_count;
      longint unsigned  top_prime;
      bit               seg_marks[SEGMENT_SIZE];
      sieve_result_type pending[$];
      int               mismatches;

      function new();
         table_count = 0;
         top_prime   = 0;
         mismatches  = 0;
      endfunction

      // append one prime; 0 when the table is already full
      function bit append_prime(longint unsigned p);
         if (table_count >= TABLE_DEPTH) return 0;
         stored_primes[table_count] = p[31:0];
         table_count++;
         top_prime = p;
         return 1;
      endfunction

      // grow the table up to limit; returns 1 when stopped by a full table
      function bit grow_table(longint unsigned limit, output longint unsigned added);
         longint unsigned lo, hi, len, i, j, k, p, r;
         added = 0;
         if (limit <= top_prime) return 0;
         if (top_prime == 0) begin
            table_count = 0;
            if (!append_prime(2)) return 1;
            added++;
         end
         if (limit <= top_prime) return 0;
         lo = top_prime + 1;
         forever begin
            if (limit - lo < SEGMENT_SIZE - 1) hi = limit;
            else hi = lo + SEGMENT_SIZE - 1;
            len = hi - lo + 1;
            for (i = 0; i < len; i++) seg_marks[i] = 1;
            for (k = 0; k < table_count; k++) begin
               p = stored_primes[k];
               if (p < 2 || p > hi / p) break;
               r = lo % p;
               j = (r == 0) ? 0 : p - r;
               for (; j < len; j += p) seg_marks[j] = 0;
            end
            for (i = 0; i < len; i++) begin
               if (seg_marks[i]) begin
                  p = lo + i;
                  if (!append_prime(p)) return 1;
                  added++;
                  if (p < len)
                     for (j = i + p; j < len; j += p) seg_marks[j] = 0;
               end
            end
            if (hi == limit) break;
            lo = hi + 1;
         end
         return 0;
      endfunction

      function void note_command(cmd_type cmd, logic [31:0] limit, logic [13:0] idx);
         sieve_result_type res;
         longint unsigned  added, k;
         res.answer = 0;
         res.status = STAT_OK;
         case (cmd)
            CMD_EXTEND: begin
               if (grow_table(limit, added)) res.status = STAT_FULL;
               res.answer = added[31:0];
            end
            CMD_EXTEND_COUNT: begin
               if (grow_table(limit, added)) res.status = STAT_FULL;
               for (k = 0; k < table_count && stored_primes[k] < limit; k++) ;
               res.answer = k[31:0];
            end
            CMD_READ: begin
               if (idx >= table_count) res.status = STAT_INDEX;
               else res.answer = stored_primes[idx];
            end
            default: begin
               table_count = 0;
               top_prime   = 0;
            end
         endcase
         res.stored_count   = table_count[13:0];
         res.largest_sieved = top_prime[31:0];
         pending.insert(pending.size(), res);
      endfunction

      function void check_result(sieve_result_type got);
         sieve_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: answer %0d", got.answer);
            return;
         end
         want = pending.pop_front();
         if (got.answer !== want.answer || got.status !== want.status ||
             got.stored_count !== want.stored_count ||
             got.largest_sieved !== want.largest_sieved) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        want.answer, want.status, want.stored_count, want.largest_sieved,
                        got.answer, got.status, got.stored_count, got.largest_sieved);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ipst_req_if req_chan ();
   ipst_rsp_if rsp_chan ();

   sieve_scoreboard sb = new();

   incremental_prime_sieve_table_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #4 clock = ~clock;

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.command     = CMD_EXTEND;
      req_chan.limit_value = '0;
      req_chan.prime_index = '0;
      rsp_chan.ready       = 1'b0;
   end

   // send one item, idling a random gap first
   task automatic send_item(cmd_type cmd, logic [31:0] limit, logic [13:0] idx);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= cmd;
      req_chan.limit_value <= limit;
      req_chan.prime_index <= idx;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      sb.note_command(cmd, limit, idx);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // result side: random stall before each item
   initial begin
      int               stall;
      sieve_result_type got;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, 5);
         rsp_chan.ready <= 1'b0;
         repeat (stall) @(posedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         got.answer         = rsp_chan.answer;
         got.status         = rsp_chan.status;
         got.stored_count   = rsp_chan.stored_count;
         got.largest_sieved = rsp_chan.largest_sieved;
         sb.check_result(got);
      end
   end

   initial begin
      int          n, sel;
      logic [31:0] lim;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // seeding on an empty table even with tiny limits
      send_item(CMD_READ, 0, 0);
      send_item(CMD_EXTEND, 0, 0);
      send_item(CMD_EXTEND, 1, 0);
      send_item(CMD_READ, 0, 0);
      send_item(CMD_READ, 0, 1);
      send_item(CMD_CLEAR, 0, 0);
      send_item(CMD_EXTEND_COUNT, 1, 0);
      send_item(CMD_EXTEND, 113, 0);
      // 114..126 holds no prime; sieved by the next extend and again by the one after
      send_item(CMD_EXTEND, 126, 0);
      send_item(CMD_EXTEND_COUNT, 127, 0);
      send_item(CMD_EXTEND_COUNT, 60, 0);
      send_item(CMD_EXTEND, 9000, 0);
      send_item(CMD_READ, 0, 29);
      send_item(CMD_CLEAR, 0, 0);
      send_item(CMD_READ, 0, 0);
      // fill the table to the top, then push on a full table
      send_item(CMD_EXTEND, 32'hFFFF_FFFF, 0);
      send_item(CMD_EXTEND, 32'hFFFF_FFFF, 0);
      send_item(CMD_EXTEND_COUNT, 32'hFFFF_FFFF, 0);
      send_item(CMD_READ, 0, 14'(TABLE_DEPTH - 1));
      send_item(CMD_READ, 0, 14'(TABLE_DEPTH));
      send_item(CMD_READ, 0, 14'h3FFF);
      send_item(CMD_CLEAR, 0, 0);

      for (n = 0; n < 100; n++) begin
         if (n == 50) drain_results();
         sel = $urandom_range(0, 99);
         if (sel < 40) begin
            lim = 32'(sb.top_prime + $urandom_range(0, 3000));
            send_item($urandom_range(0, 1) ? CMD_EXTEND : CMD_EXTEND_COUNT, lim, 0);
         end else if (sel < 50) begin
            send_item(CMD_EXTEND_COUNT, 32'($urandom_range(0, 32'(sb.top_prime + 1))), 0);
         end else if (sel < 85) begin
            if (sb.table_count != 0 && $urandom_range(0, 3) != 0)
               send_item(CMD_READ, 0, 14'($urandom_range(0, 32'(sb.table_count - 1))));
            else
               send_item(CMD_READ, 0, 14'($urandom));
         end else if (sel < 95) begin
            send_item(CMD_EXTEND, 32'($urandom_range(0, 32'(sb.top_prime))), 0);
         end else begin
            send_item(CMD_CLEAR, 0, 0);
         end
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("incremental_prime_sieve_table_unit regression: pass");
      else
         $display("incremental_prime_sieve_table_unit regression: fail");
      $finish;
   end

   initial begin
      #400_000_000;
      $display("incremental_prime_sieve_table_unit regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
